// ===== hdl/ttl_pkg.sv =====
// Package for the text token lexer.
// Holds the mode and token kind codes, the line counter width, the output queue sizes
// and the result word type. It depends on nothing else.
package ttl_pkg;

	// Width of the internal line counter. It saturates at its maximum value.
	localparam int LINE_BITS = 16;

	// Depth of the output word queue; it must be a power of two so the pointers wrap.
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = QPTR_BITS + 1;

	// Lexer modes.
	localparam logic [3:0] M_IDLE  = 4'd0;
	localparam logic [3:0] M_IDENT = 4'd1;
	localparam logic [3:0] M_NUM   = 4'd2;
	localparam logic [3:0] M_HEX   = 4'd3;
	localparam logic [3:0] M_BIN   = 4'd4;
	localparam logic [3:0] M_OCT   = 4'd5;
	localparam logic [3:0] M_STR   = 4'd6;

	// States of the true/false keyword matcher.
	localparam logic [3:0] KW_NONE   = 4'd0;
	localparam logic [3:0] KW_T      = 4'd1;
	localparam logic [3:0] KW_TR     = 4'd2;
	localparam logic [3:0] KW_TRU    = 4'd3;
	localparam logic [3:0] KW_TRUE   = 4'd4;
	localparam logic [3:0] KW_F      = 4'd5;
	localparam logic [3:0] KW_FA     = 4'd6;
	localparam logic [3:0] KW_FAL    = 4'd7;
	localparam logic [3:0] KW_FALS   = 4'd8;
	localparam logic [3:0] KW_FALSE  = 4'd9;

	// Token kinds carried on token-end words.
	localparam logic [5:0] K_IDENT   = 6'd0;
	localparam logic [5:0] K_BOOL    = 6'd1;
	localparam logic [5:0] K_INT     = 6'd2;
	localparam logic [5:0] K_FLOAT   = 6'd3;
	localparam logic [5:0] K_BIN     = 6'd4;
	localparam logic [5:0] K_OCT     = 6'd5;
	localparam logic [5:0] K_HEX     = 6'd6;
	localparam logic [5:0] K_STR     = 6'd7;
	localparam logic [5:0] K_NL      = 6'd8;
	localparam logic [5:0] K_EOF     = 6'd9;
	localparam logic [5:0] K_PERIOD  = 6'd10;
	localparam logic [5:0] K_COLON   = 6'd11;
	localparam logic [5:0] K_SEMI    = 6'd12;
	localparam logic [5:0] K_COMMA   = 6'd13;
	localparam logic [5:0] K_HASH    = 6'd14;
	localparam logic [5:0] K_AT      = 6'd15;
	localparam logic [5:0] K_EQ      = 6'd16;
	localparam logic [5:0] K_PLUS    = 6'd17;
	localparam logic [5:0] K_MINUS   = 6'd18;
	localparam logic [5:0] K_STAR    = 6'd19;
	localparam logic [5:0] K_SLASH   = 6'd20;
	localparam logic [5:0] K_PCT     = 6'd21;
	localparam logic [5:0] K_BAR     = 6'd22;
	localparam logic [5:0] K_AMP     = 6'd23;
	localparam logic [5:0] K_CARET   = 6'd24;
	localparam logic [5:0] K_LPAREN  = 6'd25;
	localparam logic [5:0] K_RPAREN  = 6'd26;
	localparam logic [5:0] K_LBRACK  = 6'd27;
	localparam logic [5:0] K_RBRACK  = 6'd28;
	localparam logic [5:0] K_LBRACE  = 6'd29;
	localparam logic [5:0] K_RBRACE  = 6'd30;
	localparam logic [5:0] K_LT      = 6'd31;
	localparam logic [5:0] K_GT      = 6'd32;
	localparam logic [5:0] K_DOLLAR  = 6'd33;
	localparam logic [5:0] K_BADBYTE = 6'd34;
	localparam logic [5:0] K_EOFSTR  = 6'd35;

	// One result word as it leaves the block.
	typedef struct packed {
		logic        is_content;
		logic [7:0]  content_byte;
		logic [5:0]  token_kind;
		logic [15:0] line_number;
		logic        last_of_run;
	} ttl_word_t;

endpackage

// ===== hdl/ttl_step.sv =====
// Lexer state and the next-state logic for one input byte.
// Produces up to two result words per byte in a single pass.
// Depends on ttl_pkg.
module ttl_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            char_in,
	input  logic                  end_mark,
	input  logic                  new_file,
	output ttl_pkg::ttl_word_t    res0,
	output ttl_pkg::ttl_word_t    res1,
	output logic [1:0]            res_cnt
);

	localparam logic [ttl_pkg::LINE_BITS-1:0] LINE_ONE = ttl_pkg::LINE_BITS'(1);
	localparam logic [ttl_pkg::LINE_BITS-1:0] LINE_MAX = '1;

	logic [3:0]                   mode_q;
	logic                         period_q;
	logic [3:0]                   kw_q;
	logic                         pempty_q;
	logic [ttl_pkg::LINE_BITS-1:0] line_q;
	logic                         err_q;

	logic [3:0]                   mode_d;
	logic                         period_d;
	logic [3:0]                   kw_d;
	logic                         pempty_d;
	logic [ttl_pkg::LINE_BITS-1:0] line_d;
	logic                         err_d;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
	endfunction

	// Advance the true/false matcher by one identifier byte.
	function automatic logic [3:0] kw_next(input logic [3:0] st, input logic [7:0] c);
		logic [3:0] r;
		r = ttl_pkg::KW_NONE;
		unique case (st)
			ttl_pkg::KW_T:    if (c == "r") r = ttl_pkg::KW_TR;
			ttl_pkg::KW_TR:   if (c == "u") r = ttl_pkg::KW_TRU;
			ttl_pkg::KW_TRU:  if (c == "e") r = ttl_pkg::KW_TRUE;
			ttl_pkg::KW_F:    if (c == "a") r = ttl_pkg::KW_FA;
			ttl_pkg::KW_FA:   if (c == "l") r = ttl_pkg::KW_FAL;
			ttl_pkg::KW_FAL:  if (c == "s") r = ttl_pkg::KW_FALS;
			ttl_pkg::KW_FALS: if (c == "e") r = ttl_pkg::KW_FALSE;
			default:          r = ttl_pkg::KW_NONE;
		endcase
		return r;
	endfunction

	// Kind of a one-character symbol; anything else is an unexpected byte.
	function automatic logic [5:0] sym_kind(input logic [7:0] c);
		logic [5:0] k;
		unique case (c)
			".":     k = ttl_pkg::K_PERIOD;
			":":     k = ttl_pkg::K_COLON;
			";":     k = ttl_pkg::K_SEMI;
			",":     k = ttl_pkg::K_COMMA;
			"#":     k = ttl_pkg::K_HASH;
			"@":     k = ttl_pkg::K_AT;
			"=":     k = ttl_pkg::K_EQ;
			"+":     k = ttl_pkg::K_PLUS;
			"-":     k = ttl_pkg::K_MINUS;
			"*":     k = ttl_pkg::K_STAR;
			"/":     k = ttl_pkg::K_SLASH;
			"%":     k = ttl_pkg::K_PCT;
			"|":     k = ttl_pkg::K_BAR;
			"&":     k = ttl_pkg::K_AMP;
			"^":     k = ttl_pkg::K_CARET;
			"(":     k = ttl_pkg::K_LPAREN;
			")":     k = ttl_pkg::K_RPAREN;
			"[":     k = ttl_pkg::K_LBRACK;
			"]":     k = ttl_pkg::K_RBRACK;
			"{":     k = ttl_pkg::K_LBRACE;
			"}":     k = ttl_pkg::K_RBRACE;
			"<":     k = ttl_pkg::K_LT;
			">":     k = ttl_pkg::K_GT;
			default: k = ttl_pkg::K_BADBYTE;
		endcase
		return k;
	endfunction

	// Next state and result words for the current byte.
	always_comb begin
		logic                          a_v;
		logic                          a_content;
		logic [5:0]                    a_kind;
		logic                          b_v;
		logic                          b_content;
		logic [5:0]                    b_kind;
		logic                          fresh;
		logic                          ok;
		logic [5:0]                    pkind;
		logic [15:0]                   line_out;
		ttl_pkg::ttl_word_t            wa;
		ttl_pkg::ttl_word_t            wb;

		// A new file resets the whole lexer before the byte is looked at.
		if (new_file) begin
			mode_d   = ttl_pkg::M_IDLE;
			period_d = 1'b0;
			kw_d     = ttl_pkg::KW_NONE;
			pempty_d = 1'b1;
			line_d   = LINE_ONE;
			err_d    = 1'b0;
		end else begin
			mode_d   = mode_q;
			period_d = period_q;
			kw_d     = kw_q;
			pempty_d = pempty_q;
			line_d   = line_q;
			err_d    = err_q;
		end

		// Words carry the line before any newline increment.
		if (32'(line_d) > 32'hFFFF) begin
			line_out = 16'hFFFF;
		end else begin
			line_out = 16'(line_d);
		end

		a_v       = 1'b0;
		a_content = 1'b0;
		a_kind    = ttl_pkg::K_IDENT;
		b_v       = 1'b0;
		b_content = 1'b0;
		b_kind    = ttl_pkg::K_IDENT;
		fresh     = 1'b0;
		ok        = 1'b0;
		pkind     = ttl_pkg::K_HEX;

		if (!err_d) begin
			// Continue or close the token in progress.
			unique case (mode_d)
				ttl_pkg::M_IDENT: begin
					a_v = 1'b1;
					if (!end_mark && (is_alpha(char_in) || is_digit(char_in) || char_in == "_"))
					begin
						kw_d      = kw_next(kw_d, char_in);
						a_content = 1'b1;
					end else begin
						a_kind = (kw_d == ttl_pkg::KW_TRUE || kw_d == ttl_pkg::KW_FALSE) ?
							ttl_pkg::K_BOOL : ttl_pkg::K_IDENT;
						fresh  = 1'b1;
					end
				end
				ttl_pkg::M_NUM: begin
					a_v = 1'b1;
					if (!end_mark && is_digit(char_in)) begin
						a_content = 1'b1;
					end else if (!end_mark && char_in == "." && !period_d) begin
						period_d  = 1'b1;
						a_content = 1'b1;
					end else begin
						a_kind = period_d ? ttl_pkg::K_FLOAT : ttl_pkg::K_INT;
						fresh  = 1'b1;
					end
				end
				ttl_pkg::M_HEX, ttl_pkg::M_BIN, ttl_pkg::M_OCT: begin
					a_v = 1'b1;
					if (mode_d == ttl_pkg::M_HEX) begin
						ok    = is_hex(char_in);
						pkind = pempty_d ? ttl_pkg::K_DOLLAR : ttl_pkg::K_HEX;
					end else if (mode_d == ttl_pkg::M_BIN) begin
						ok    = char_in == "0" || char_in == "1";
						pkind = pempty_d ? ttl_pkg::K_PCT : ttl_pkg::K_BIN;
					end else begin
						ok    = char_in >= "0" && char_in <= "7";
						pkind = pempty_d ? ttl_pkg::K_AMP : ttl_pkg::K_OCT;
					end
					if (!end_mark && ok) begin
						pempty_d  = 1'b0;
						a_content = 1'b1;
					end else begin
						a_kind = pkind;
						fresh  = 1'b1;
					end
				end
				ttl_pkg::M_STR: begin
					a_v = 1'b1;
					if (end_mark) begin
						a_kind = ttl_pkg::K_EOFSTR;
						err_d  = 1'b1;
						mode_d = ttl_pkg::M_IDLE;
					end else if (char_in == "\"") begin
						a_kind = ttl_pkg::K_STR;
						mode_d = ttl_pkg::M_IDLE;
					end else begin
						a_content = 1'b1;
					end
				end
				default: begin
					fresh = 1'b1;
				end
			endcase

			// The byte that closed a token, or a byte between tokens, may start a new one.
			if (fresh) begin
				mode_d = ttl_pkg::M_IDLE;
				if (end_mark) begin
					b_v    = 1'b1;
					b_kind = ttl_pkg::K_EOF;
				end else if (char_in == 8'h0A) begin
					b_v    = 1'b1;
					b_kind = ttl_pkg::K_NL;
					if (line_d != LINE_MAX) begin
						line_d = line_d + LINE_ONE;
					end
				end else if (is_blank(char_in)) begin
					b_v = 1'b0;
				end else if (is_alpha(char_in) || char_in == "_") begin
					mode_d    = ttl_pkg::M_IDENT;
					kw_d      = (char_in == "t") ? ttl_pkg::KW_T :
					            (char_in == "f") ? ttl_pkg::KW_F : ttl_pkg::KW_NONE;
					b_v       = 1'b1;
					b_content = 1'b1;
				end else if (char_in == "\"") begin
					mode_d = ttl_pkg::M_STR;
				end else if (is_digit(char_in)) begin
					mode_d    = ttl_pkg::M_NUM;
					period_d  = 1'b0;
					b_v       = 1'b1;
					b_content = 1'b1;
				end else if (char_in == "$" || char_in == "%" || char_in == "&") begin
					mode_d   = (char_in == "$") ? ttl_pkg::M_HEX :
					           (char_in == "%") ? ttl_pkg::M_BIN : ttl_pkg::M_OCT;
					pempty_d = 1'b1;
				end else begin
					b_v    = 1'b1;
					b_kind = sym_kind(char_in);
					if (b_kind == ttl_pkg::K_BADBYTE) begin
						err_d = 1'b1;
					end
				end
			end
		end

		// Build the two candidate words.
		wa.is_content   = a_content;
		wa.content_byte = a_content ? char_in : 8'd0;
		wa.token_kind   = a_content ? ttl_pkg::K_IDENT : a_kind;
		wa.line_number  = line_out;
		wa.last_of_run  = !b_v;
		wb.is_content   = b_content;
		wb.content_byte = b_content ? char_in : 8'd0;
		wb.token_kind   = b_content ? ttl_pkg::K_IDENT : b_kind;
		wb.line_number  = line_out;
		wb.last_of_run  = 1'b1;

		// Pack the valid words to the front.
		res0    = a_v ? wa : wb;
		res1    = wb;
		res_cnt = {1'b0, a_v} + {1'b0, b_v};
	end

	// Lexer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ttl_pkg::M_IDLE;
			period_q <= 1'b0;
			kw_q     <= ttl_pkg::KW_NONE;
			pempty_q <= 1'b1;
			line_q   <= LINE_ONE;
			err_q    <= 1'b0;
		end else if (fire) begin
			mode_q   <= mode_d;
			period_q <= period_d;
			kw_q     <= kw_d;
			pempty_q <= pempty_d;
			line_q   <= line_d;
			err_q    <= err_d;
		end
	end

endmodule

// ===== hdl/text_token_lexer.sv =====
// Text token lexer top level: input register, lexer step, four-word output queue.
// An accepted byte waits in the input register; its words then go into the output queue.
// Throughput: one byte per cycle while each byte gives at most one word and out_stall is low;
// a byte giving two words puts both in the queue, and the queue absorbs short bursts of those.
// Reset (arst_n low, asynchronous) empties the queue and sets the lexer idle at line 1.
// Depends on ttl_pkg and ttl_step.
module text_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        end_mark,
	input  logic        new_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_content,
	output logic [7:0]  content_byte,
	output logic [5:0]  token_kind,
	output logic [15:0] line_number,
	output logic        last_of_run
);

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 eof_s1;
	logic                 nf_s1;

	ttl_pkg::ttl_word_t   res0;
	ttl_pkg::ttl_word_t   res1;
	logic [1:0]           res_cnt;

	ttl_pkg::ttl_word_t   q_mem [ttl_pkg::QDEPTH];
	logic [ttl_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [ttl_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [ttl_pkg::QCNT_BITS-1:0] count_q;

	logic                 consume;
	logic                 pop;
	ttl_pkg::ttl_word_t   head;

	// The registered word is processed once the queue has room for two words.
	assign consume  = valid_s1 && (count_q <= ttl_pkg::QCNT_BITS'(ttl_pkg::QDEPTH - 2));
	assign in_stall = valid_s1 && !consume;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			eof_s1  <= end_mark;
			nf_s1   <= new_file;
		end
	end

	ttl_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (consume),
		.char_in  (char_s1),
		.end_mark (eof_s1),
		.new_file (nf_s1),
		.res0     (res0),
		.res1     (res1),
		.res_cnt  (res_cnt)
	);

	// Output queue: head word drives the ports.
	assign head         = q_mem[rd_ptr_q];
	assign out_valid    = count_q != '0;
	assign pop          = out_valid && !out_stall;
	assign is_content   = head.is_content;
	assign content_byte = head.content_byte;
	assign token_kind   = head.token_kind;
	assign line_number  = head.line_number;
	assign last_of_run  = head.last_of_run;

	always_ff @(posedge clk) begin
		if (consume && res_cnt != 2'd0) begin
			q_mem[wr_ptr_q] <= res0;
		end
		if (consume && res_cnt == 2'd2) begin
			q_mem[wr_ptr_q + ttl_pkg::QPTR_BITS'(1)] <= res1;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (consume) begin
				wr_ptr_q <= wr_ptr_q + ttl_pkg::QPTR_BITS'(res_cnt);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ttl_pkg::QPTR_BITS'(1);
			end
			count_q <= count_q + (consume ? ttl_pkg::QCNT_BITS'(res_cnt) : '0) -
				ttl_pkg::QCNT_BITS'(pop);
		end
	end

endmodule
